FILE: hw/rtl/run_stopwatch_hms_unit_defines.svh
// ----------------------------------------------------------------------------
// Run stopwatch assertion macros
// Shared concurrent assertion forms for the run stopwatch block.
// ----------------------------------------------------------------------------
`ifndef RUN_STOPWATCH_HMS_UNIT_DEFINES_SVH
`define RUN_STOPWATCH_HMS_UNIT_DEFINES_SVH

// same-cycle implication
`define RSW_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("run stopwatch: same-cycle check failed");

// next-cycle implication
`define RSW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("run stopwatch: next-cycle check failed");

`endif

FILE: hw/rtl/rsw_pkg.sv
// ----------------------------------------------------------------------------
// Run stopwatch package
// Operation and result codes and the divide-by-sixty helper.
// ----------------------------------------------------------------------------
package rsw_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_RESET = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_UPDATE = 2'd0,
    KIND_START  = 2'd1,
    KIND_RESET  = 2'd2
  } kind_t;

  localparam int unsigned ELAPSED_W = 40;
  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned MS_W      = 10;
  localparam int unsigned DIV_IN_W  = 17;
  localparam int unsigned DIV_Q_W   = 12;
  localparam int unsigned DIV_SHIFT = 23;
  localparam logic [17:0] DIV60_MUL = 18'd139811;
  localparam logic [9:0]  MS_SCALE  = 10'd1000;
  localparam logic [5:0]  BASE60    = 6'd60;
  localparam int unsigned OQ_DEPTH  = 2;

  typedef struct packed {
    logic [DIV_Q_W-1:0] quo;
    logic [5:0]         rem;
  } divmod_t;

  // exact reciprocal divide by sixty for inputs below 2**17
  function automatic divmod_t div60(input logic [DIV_IN_W-1:0] x);
    logic [DIV_IN_W+17:0] prod;
    logic [DIV_IN_W-1:0]  back;
    divmod_t              res;
    prod     = (DIV_IN_W+18)'(x) * (DIV_IN_W+18)'(DIV60_MUL);
    res.quo  = prod[DIV_SHIFT +: DIV_Q_W];
    back     = DIV_IN_W'(res.quo) * DIV_IN_W'(BASE60);
    res.rem  = 6'(x - back);
    return res;
  endfunction

endpackage

FILE: hw/rtl/run_stopwatch_hms_unit.sv
// ----------------------------------------------------------------------------
// Run stopwatch unit
// Stopwatch in hours, minutes, seconds and milliseconds. Every accepted operation
// word updates the time registers when it is taken; a new word can follow in
// every cycle while the queue is not full. Results go to a two-entry output
// queue, each entry holding all results of one word. A reset word gives two
// result words on successive accepted output transfers (old time, then cleared
// time). The input stalls only while the queue is full. The carry into minutes
// and hours uses a reciprocal multiply by 1/60; milliseconds are formed from
// the queued fraction at the output.
// ----------------------------------------------------------------------------
`include "run_stopwatch_hms_unit_defines.svh"

module run_stopwatch_hms_unit #(
  parameter int unsigned FRAC_BITS  = 32,
  parameter int unsigned WHOLE_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_opcode,
  input  logic [rsw_pkg::ELAPSED_W-1:0]     in_elapsed,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_kind,
  output logic [rsw_pkg::COUNT_W-1:0]       out_hours_out,
  output logic [5:0]                        out_minutes_out,
  output logic [5:0]                        out_seconds_out,
  output logic [rsw_pkg::MS_W-1:0]          out_millis_out,
  output logic [rsw_pkg::COUNT_W-1:0]       out_frames_out,
  output logic                              out_second_changed,
  output logic                              out_last_result
);

  localparam int unsigned SUM_W   = WHOLE_BITS + FRAC_BITS + 1;
  localparam int unsigned WIDE_W  = rsw_pkg::ELAPSED_W + SUM_W;
  localparam int unsigned PTR_W   = $clog2(rsw_pkg::OQ_DEPTH);
  localparam int unsigned CNT_W   = $clog2(rsw_pkg::OQ_DEPTH + 1);
  localparam int unsigned MSP_W   = FRAC_BITS + rsw_pkg::MS_W;
  localparam logic [SUM_W-1:0] EL_MASK = (SUM_W'(1) << (WHOLE_BITS + FRAC_BITS)) - SUM_W'(1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(rsw_pkg::OQ_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(rsw_pkg::OQ_DEPTH - 1);

  typedef struct packed {
    rsw_pkg::kind_t              kind;
    logic [rsw_pkg::COUNT_W-1:0] hours;
    logic [5:0]                  mins;
    logic [5:0]                  secs;
    logic [FRAC_BITS-1:0]        frac;
    logic [rsw_pkg::COUNT_W-1:0] frames;
    logic                        changed;
    logic                        pair;
  } entry_t;

  logic                        running_r, running_nxt;
  logic [rsw_pkg::COUNT_W-1:0] hour_r, hour_nxt;
  logic [5:0]                  minute_r, minute_nxt;
  logic [5:0]                  second_r, second_nxt;
  logic [FRAC_BITS-1:0]        frac_r, frac_nxt;
  logic [rsw_pkg::COUNT_W-1:0] frame_r, frame_nxt;

  entry_t                      queue_r [rsw_pkg::OQ_DEPTH];
  logic [PTR_W-1:0]            wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]            count_r;
  logic                        phase_r;

  logic                        in_accept, out_accept, push, pop;
  entry_t                      push_entry, head;
  rsw_pkg::op_t                op;
  logic [WIDE_W-1:0]           el_wide;
  logic [SUM_W-1:0]            el, sum;
  rsw_pkg::divmod_t            sec_dm, min_dm;
  logic [rsw_pkg::COUNT_W:0]   hrs_sum;
  logic [MSP_W-1:0]            ms_prod;

  assign in_stall   = (count_r == DEPTH_C);
  assign in_accept  = in_valid && !in_stall;
  assign out_valid  = (count_r != '0);
  assign out_accept = out_valid && !out_stall;
  assign head       = queue_r[rd_ptr_r];
  assign pop        = out_accept && !(head.pair && !phase_r);
  assign op         = rsw_pkg::op_t'(in_opcode);

  assign el_wide = WIDE_W'(in_elapsed);
  assign el      = el_wide[SUM_W-1:0] & EL_MASK;
  assign sum     = SUM_W'(frac_r) + el;
  assign sec_dm  = rsw_pkg::div60(rsw_pkg::DIV_IN_W'(second_r) +
                                  rsw_pkg::DIV_IN_W'(sum[SUM_W-1:FRAC_BITS]));
  assign min_dm  = rsw_pkg::div60(rsw_pkg::DIV_IN_W'(minute_r) +
                                  rsw_pkg::DIV_IN_W'(sec_dm.quo));
  assign hrs_sum = (rsw_pkg::COUNT_W+1)'(hour_r) + (rsw_pkg::COUNT_W+1)'(min_dm.quo);

  always_comb begin
    running_nxt = running_r;
    hour_nxt    = hour_r;
    minute_nxt  = minute_r;
    second_nxt  = second_r;
    frac_nxt    = frac_r;
    frame_nxt   = frame_r;
    push        = 1'b0;
    push_entry.kind    = rsw_pkg::KIND_UPDATE;
    push_entry.hours   = hour_r;
    push_entry.mins    = minute_r;
    push_entry.secs    = second_r;
    push_entry.frac    = frac_r;
    push_entry.frames  = frame_r;
    push_entry.changed = 1'b0;
    push_entry.pair    = 1'b0;
    if (in_accept) begin
      case (op)
        rsw_pkg::OP_TICK: begin
          if (running_r) begin
            push       = 1'b1;
            frame_nxt  = (frame_r == '1) ? frame_r : frame_r + 1'b1;
            frac_nxt   = sum[FRAC_BITS-1:0];
            second_nxt = sec_dm.rem;
            minute_nxt = min_dm.rem;
            hour_nxt   = hrs_sum[rsw_pkg::COUNT_W] ? '1 : hrs_sum[rsw_pkg::COUNT_W-1:0];
            push_entry.hours   = hour_nxt;
            push_entry.mins    = minute_nxt;
            push_entry.secs    = second_nxt;
            push_entry.frac    = frac_nxt;
            push_entry.frames  = frame_nxt;
            push_entry.changed = (second_nxt != second_r);
          end
        end
        rsw_pkg::OP_START: begin
          if (!running_r) begin
            push            = 1'b1;
            push_entry.kind = rsw_pkg::KIND_START;
            running_nxt     = 1'b1;
          end
        end
        rsw_pkg::OP_STOP: begin
          running_nxt = 1'b0;
        end
        rsw_pkg::OP_RESET: begin
          push            = 1'b1;
          push_entry.kind = rsw_pkg::KIND_RESET;
          push_entry.pair = 1'b1;
          running_nxt     = 1'b0;
          hour_nxt        = '0;
          minute_nxt      = '0;
          second_nxt      = '0;
          frac_nxt        = '0;
          frame_nxt       = '0;
        end
        default: begin
          running_nxt = running_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      hour_r    <= '0;
      minute_r  <= '0;
      second_r  <= '0;
      frac_r    <= '0;
      frame_r   <= '0;
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      count_r   <= '0;
      phase_r   <= 1'b0;
    end else begin
      running_r <= running_nxt;
      hour_r    <= hour_nxt;
      minute_r  <= minute_nxt;
      second_r  <= second_nxt;
      frac_r    <= frac_nxt;
      frame_r   <= frame_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + CNT_W'(push) - CNT_W'(pop);
      if (out_accept) begin
        phase_r <= !pop;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= push_entry;
    end
  end

  // second word of a reset pair is the cleared time
  assign ms_prod = MSP_W'(head.frac) * MSP_W'(rsw_pkg::MS_SCALE);

  always_comb begin
    if (phase_r) begin
      out_kind           = rsw_pkg::KIND_UPDATE;
      out_hours_out      = '0;
      out_minutes_out    = '0;
      out_seconds_out    = '0;
      out_millis_out     = '0;
      out_frames_out     = '0;
      out_second_changed = 1'b0;
      out_last_result    = 1'b1;
    end else begin
      out_kind           = head.kind;
      out_hours_out      = head.hours;
      out_minutes_out    = head.mins;
      out_seconds_out    = head.secs;
      out_millis_out     = ms_prod[FRAC_BITS +: rsw_pkg::MS_W];
      out_frames_out     = head.frames;
      out_second_changed = head.changed;
      out_last_result    = !head.pair;
    end
  end

  `RSW_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= DEPTH_C)
  `RSW_ASSERT_NOW(a_phase_pair, clk, rst_n, phase_r, out_valid && head.pair)
  `RSW_ASSERT_NEXT(a_reset_queued, clk, rst_n, in_accept && op == rsw_pkg::OP_RESET,
    out_valid && !running_r && frame_r == '0)
  `RSW_ASSERT_NEXT(a_start_runs, clk, rst_n, in_accept && op == rsw_pkg::OP_START,
    running_r)

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// Run stopwatch unit testbench
// A queue-fed driver sends directed and random operation words: start, tick,
// stop and reset sequences with random elapsed times. A monitor predicts every
// result word from its own copy of the watch state and checks the output
// stream field by field. Both sides idle and stall at random. The receiver
// holds off once for a long stretch, and the sender drains twice.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAC_BITS      = 32;
  localparam int unsigned WHOLE_BITS     = 8;
  localparam int unsigned CLK_PERIOD     = 10;
  localparam int unsigned WORD_TARGET    = 1350;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned LONG_HOLD      = 80;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam logic [31:0] COUNT_MAX      = 32'hFFFF_FFFF;

  typedef struct packed {
    logic                          drain;
    rsw_pkg::op_t                  op;
    logic [rsw_pkg::ELAPSED_W-1:0] elapsed;
  } op_word_t;

  typedef struct packed {
    logic [1:0]                  kind;
    logic [rsw_pkg::COUNT_W-1:0] hours;
    logic [5:0]                  minutes;
    logic [5:0]                  seconds;
    logic [rsw_pkg::MS_W-1:0]    millis;
    logic [rsw_pkg::COUNT_W-1:0] frames;
    logic                        changed;
    logic                        last;
  } watch_time_t;

  logic                          clk                = 1'b0;
  logic                          rst_n              = 1'b0;
  logic                          in_valid           = 1'b0;
  logic                          in_stall;
  logic [1:0]                    in_opcode          = rsw_pkg::OP_TICK;
  logic [rsw_pkg::ELAPSED_W-1:0] in_elapsed         = '0;
  logic                          out_valid;
  logic                          out_stall          = 1'b0;
  logic [1:0]                    out_kind;
  logic [rsw_pkg::COUNT_W-1:0]   out_hours_out;
  logic [5:0]                    out_minutes_out;
  logic [5:0]                    out_seconds_out;
  logic [rsw_pkg::MS_W-1:0]      out_millis_out;
  logic [rsw_pkg::COUNT_W-1:0]   out_frames_out;
  logic                          out_second_changed;
  logic                          out_last_result;

  op_word_t    op_words[$];
  watch_time_t expected_times[$];

  logic                        watch_running = 1'b0;
  logic [rsw_pkg::COUNT_W-1:0] hour_cnt      = '0;
  logic [5:0]                  minute_cnt    = '0;
  logic [5:0]                  second_cnt    = '0;
  logic [63:0]                 frac_acc      = '0;
  logic [rsw_pkg::COUNT_W-1:0] frame_cnt     = '0;

  int unsigned words_queued   = 0;
  int unsigned words_accepted = 0;
  int unsigned results_seen   = 0;
  int unsigned mismatches     = 0;
  int unsigned cyc            = 0;
  int unsigned idle_cycles    = 0;
  int unsigned send_gap       = 0;
  int unsigned stall_left     = 0;
  int unsigned hold_left      = 0;
  bit          hold_done      = 1'b0;

  run_stopwatch_hms_unit #(
    .FRAC_BITS  (FRAC_BITS),
    .WHOLE_BITS (WHOLE_BITS)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_elapsed         (in_elapsed),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_hours_out      (out_hours_out),
    .out_minutes_out    (out_minutes_out),
    .out_seconds_out    (out_seconds_out),
    .out_millis_out     (out_millis_out),
    .out_frames_out     (out_frames_out),
    .out_second_changed (out_second_changed),
    .out_last_result    (out_last_result)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (cyc[9:8] == 2'b11 || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [rsw_pkg::ELAPSED_W-1:0] rand_elapsed();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return {8'd0, 32'($urandom())};
    if (r < 60) return {8'($urandom_range(0, 3)), 32'($urandom())};
    if (r < 80) return {8'($urandom()), 32'($urandom())};
    if (r < 88) return {8'($urandom()), 32'd0};
    if (r < 94) return '0;
    return '1;
  endfunction

  function automatic watch_time_t time_snapshot(rsw_pkg::kind_t kind, logic changed,
                                                logic last);
    watch_time_t t;
    logic [63:0] ms;
    ms        = ((frac_acc & ((64'd1 << FRAC_BITS) - 1)) * 64'd1000) >> FRAC_BITS;
    t.kind    = kind;
    t.hours   = hour_cnt;
    t.minutes = minute_cnt;
    t.seconds = second_cnt;
    t.millis  = ms[rsw_pkg::MS_W-1:0];
    t.frames  = frame_cnt;
    t.changed = changed;
    t.last    = last;
    return t;
  endfunction

  task automatic apply_stopwatch_op(rsw_pkg::op_t op,
                                    logic [rsw_pkg::ELAPSED_W-1:0] elapsed);
    logic [63:0] el, sum, secs, mins, hrs;
    logic [5:0]  prev_sec;
    el = 64'(elapsed) & ((64'd1 << (WHOLE_BITS + FRAC_BITS)) - 1);
    case (op)
      rsw_pkg::OP_TICK: begin
        if (!watch_running) return;
        prev_sec = second_cnt;
        if (frame_cnt != COUNT_MAX) frame_cnt = frame_cnt + 1;
        sum        = frac_acc + el;
        frac_acc   = sum & ((64'd1 << FRAC_BITS) - 1);
        secs       = 64'(second_cnt) + (sum >> FRAC_BITS);
        mins       = 64'(minute_cnt) + secs / 60;
        hrs        = 64'(hour_cnt) + mins / 60;
        second_cnt = 6'(secs % 60);
        minute_cnt = 6'(mins % 60);
        hour_cnt   = (hrs > 64'(COUNT_MAX)) ? COUNT_MAX : hrs[31:0];
        expected_times.push_back(
          time_snapshot(rsw_pkg::KIND_UPDATE, prev_sec != second_cnt, 1'b1));
      end
      rsw_pkg::OP_START: begin
        if (watch_running) return;
        expected_times.push_back(time_snapshot(rsw_pkg::KIND_START, 1'b0, 1'b1));
        watch_running = 1'b1;
      end
      rsw_pkg::OP_STOP: begin
        watch_running = 1'b0;
      end
      default: begin
        expected_times.push_back(time_snapshot(rsw_pkg::KIND_RESET, 1'b0, 1'b0));
        watch_running = 1'b0;
        hour_cnt      = '0;
        minute_cnt    = '0;
        second_cnt    = '0;
        frac_acc      = '0;
        frame_cnt     = '0;
        expected_times.push_back(time_snapshot(rsw_pkg::KIND_UPDATE, 1'b0, 1'b1));
      end
    endcase
  endtask

  task automatic report_mismatch(string what, watch_time_t want, watch_time_t got);
    string want_s, got_s;
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      want_s = $sformatf("kind=%0d h=%0d m=%0d s=%0d ms=%0d fr=%0d chg=%0b last=%0b",
                         want.kind, want.hours, want.minutes, want.seconds, want.millis,
                         want.frames, want.changed, want.last);
      got_s  = $sformatf("kind=%0d h=%0d m=%0d s=%0d ms=%0d fr=%0d chg=%0b last=%0b",
                         got.kind, got.hours, got.minutes, got.seconds, got.millis,
                         got.frames, got.changed, got.last);
      $display("%0t %s: exp %s | act %s", $realtime, what, want_s, got_s);
    end
  endtask

  task automatic check_time_word();
    watch_time_t got, want;
    got.kind    = out_kind;
    got.hours   = out_hours_out;
    got.minutes = out_minutes_out;
    got.seconds = out_seconds_out;
    got.millis  = out_millis_out;
    got.frames  = out_frames_out;
    got.changed = out_second_changed;
    got.last    = out_last_result;
    if (expected_times.size() == 0) begin
      report_mismatch("unexpected word", '0, got);
      return;
    end
    want = expected_times.pop_front();
    if (got.kind !== want.kind || got.hours !== want.hours || got.minutes !== want.minutes ||
        got.seconds !== want.seconds || got.millis !== want.millis ||
        got.frames !== want.frames || got.changed !== want.changed || got.last !== want.last)
      report_mismatch("mismatch", want, got);
  endtask

  task automatic queue_word(rsw_pkg::op_t op, logic [rsw_pkg::ELAPSED_W-1:0] elapsed);
    op_words.push_back('{drain: 1'b0, op: op, elapsed: elapsed});
    words_queued++;
  endtask

  task automatic queue_drain();
    op_words.push_back('{drain: 1'b1, op: rsw_pkg::OP_TICK, elapsed: '0});
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else if (!in_valid || !in_stall) begin
      logic     next_valid;
      op_word_t w;
      next_valid = 1'b0;
      if (send_gap != 0) begin
        send_gap--;
      end else if (op_words.size() != 0) begin
        if (op_words[0].drain) begin
          if (!in_valid && expected_times.size() == 0) void'(op_words.pop_front());
        end else begin
          w = op_words.pop_front();
          in_opcode  <= w.op;
          in_elapsed <= w.elapsed;
          next_valid = 1'b1;
          send_gap   = pick_gap();
        end
      end
      in_valid <= next_valid;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && results_seen >= 300) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_left = pick_gap();
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        apply_stopwatch_op(rsw_pkg::op_t'(in_opcode), in_elapsed);
        words_accepted++;
      end
      if (out_valid && !out_stall) begin
        check_time_word();
        results_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cyc++;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int unsigned r;
    bit          drained_mid;
    drained_mid = 1'b0;

    queue_word(rsw_pkg::OP_TICK, {8'd5, 32'd0});
    queue_word(rsw_pkg::OP_RESET, '0);
    queue_word(rsw_pkg::OP_START, '0);
    queue_word(rsw_pkg::OP_START, '1);
    queue_word(rsw_pkg::OP_TICK, '0);
    queue_word(rsw_pkg::OP_TICK, {8'd0, 32'hFFFF_FFFF});
    queue_word(rsw_pkg::OP_TICK, '1);
    queue_word(rsw_pkg::OP_TICK, 40'd1);
    queue_word(rsw_pkg::OP_STOP, '0);
    queue_word(rsw_pkg::OP_TICK, '1);
    queue_word(rsw_pkg::OP_START, '0);
    repeat (13) queue_word(rsw_pkg::OP_TICK, '1);
    queue_word(rsw_pkg::OP_RESET, '1);
    queue_drain();

    while (words_queued < WORD_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        queue_word(rsw_pkg::OP_START, rand_elapsed());
        repeat ($urandom_range(1, 30)) queue_word(rsw_pkg::OP_TICK, rand_elapsed());
        r = $urandom_range(0, 99);
        if (r < 45) queue_word(rsw_pkg::OP_STOP, rand_elapsed());
        else if (r < 65) queue_word(rsw_pkg::OP_RESET, rand_elapsed());
      end else begin
        repeat ($urandom_range(1, 4))
          queue_word(rsw_pkg::op_t'($urandom_range(0, 3)), rand_elapsed());
      end
      if (!drained_mid && words_queued >= WORD_TARGET / 2) begin
        queue_drain();
        drained_mid = 1'b1;
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    while (words_accepted != words_queued || expected_times.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_times.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
